[rtl/fte_pkg.sv]
// Shared types and constants for the binary indexed tree engine.
package fte_pkg;

  localparam int SUM_W = 32;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // write zero at the sweep address and advance it
    logic load;      // capture an input item and issue its first read
    logic step;      // consume one node read and issue the next
    logic out_load;  // move the finished result into the output register
  } fte_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;   // sweep is at the last entry
    logic load_walk;    // item at the input needs a tree walk
    logic load_result;  // item at the input gives a result
    logic walk_done;    // current node is the last of the walk
    logic held_result;  // item in work gives a result
  } fte_sts_t;

endpackage

[rtl/fte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/fte_ctrl.sv]
// Control state machine: clearing sweep, item intake, tree walk and result hand-off.
module fte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fte_pkg::fte_sts_t sts,
  output fte_pkg::fte_cmd_t cmd
);
  import fte_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.load_walk) begin
            state_next = ST_WALK;
          end else if (sts.load_result) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_done) begin
          state_next = sts.held_result ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/fte_datapath.sv]
// Datapath: node store, walk registers, per-level arithmetic and output register.
module fte_datapath #(
  parameter int LOG_SIZE = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fte_pkg::fte_cmd_t         cmd,
  output fte_pkg::fte_sts_t         sts,
  input  logic [1:0]                operation,
  input  logic [LOG_SIZE:0]         index,
  input  logic signed [31:0]        delta,
  input  logic signed [31:0]        target,
  output logic signed [31:0]        prefix_sum,
  output logic [LOG_SIZE:0]         found_position
);
  import fte_pkg::*;

  localparam int POS_W = LOG_SIZE + 1;
  localparam int DEPTH = 1 << LOG_SIZE;
  localparam logic [POS_W-1:0] SIZE_POS = {1'b1, {LOG_SIZE{1'b0}}};
  localparam logic [LOG_SIZE-1:0] LAST_ADDR = {LOG_SIZE{1'b1}};

  // Node N lives at address N mod SIZE; entry 0 is never used, so node SIZE takes it.
  logic [OP_W-1:0]     op_q;
  logic [SUM_W-1:0]    delta_q;
  logic [POS_W-1:0]    node, node_next, node_load;
  logic [POS_W-1:0]    base, base_next;
  logic [POS_W-1:0]    step, step_next;
  logic [SUM_W-1:0]    acc, acc_next;
  logic [LOG_SIZE-1:0] clr_addr;
  logic                walk_done;

  logic [POS_W-1:0]    low_bit;
  logic [POS_W:0]      up_pos;
  logic                take;

  logic                wr_en;
  logic [LOG_SIZE-1:0] wr_addr, rd_addr;
  logic [SUM_W-1:0]    wr_data, rd_data;

  // Decode the item at the input and gather the status for the controller
  always_comb begin
    node_load       = index;
    sts.load_walk   = 1'b0;
    sts.load_result = 1'b0;
    unique case (operation)
      OP_ADD: begin
        sts.load_walk = (index != '0) && (index <= SIZE_POS);
      end
      OP_PREFIX: begin
        node_load       = (index > SIZE_POS) ? SIZE_POS : index;
        sts.load_walk   = (index != '0);
        sts.load_result = 1'b1;
      end
      OP_SELECT: begin
        node_load       = SIZE_POS;
        sts.load_walk   = 1'b1;
        sts.load_result = 1'b1;
      end
      default: begin
        sts.load_walk   = 1'b0;
        sts.load_result = 1'b0;
      end
    endcase
    sts.walk_done   = walk_done;
    sts.held_result = (op_q == OP_PREFIX) || (op_q == OP_SELECT);
    sts.clear_last  = (clr_addr == LAST_ADDR);
  end

  // One tree level per cycle: rd_data holds the node read last cycle
  assign low_bit = node & (~node + POS_W'(1));
  assign up_pos  = {1'b0, node} + {1'b0, low_bit};
  assign take    = (node <= SIZE_POS) && ($signed(acc) >= $signed(rd_data));

  always_comb begin
    node_next = node;
    base_next = base;
    step_next = step;
    acc_next  = acc;
    walk_done = 1'b1;
    case (op_q)
      OP_ADD: begin
        node_next = up_pos[POS_W-1:0];
        walk_done = (up_pos > {1'b0, SIZE_POS});
      end
      OP_PREFIX: begin
        acc_next  = acc + rd_data;
        node_next = node - low_bit;
        walk_done = (node_next == '0);
      end
      OP_SELECT: begin
        if (take) begin
          base_next = node;
          acc_next  = acc - rd_data;
        end
        step_next = step >> 1;
        node_next = base_next + step_next;
        walk_done = (step_next == '0) || (base_next >= SIZE_POS);
      end
      default: walk_done = 1'b1;
    endcase
  end

  // Store ports: the sweep and the add walk write, every walk reads ahead
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node[LOG_SIZE-1:0];
    wr_data = rd_data + delta_q;
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.step && (op_q == OP_ADD)) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = cmd.load ? node_load[LOG_SIZE-1:0] : node_next[LOG_SIZE-1:0];

  fte_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + LOG_SIZE'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      delta_q <= delta;
      node    <= node_load;
      base    <= '0;
      step    <= SIZE_POS;
      acc     <= (operation == OP_SELECT) ? target : '0;
    end else if (cmd.step) begin
      node <= node_next;
      base <= base_next;
      step <= step_next;
      acc  <= acc_next;
    end
    if (cmd.out_load) begin
      prefix_sum     <= (op_q == OP_PREFIX) ? acc : '0;
      found_position <= (op_q == OP_SELECT) ? base : '0;
    end
  end

endmodule

[rtl/fenwick_tree_engine.sv]
// Top level of the binary indexed tree engine: add, prefix sum and select over 2^LOG_SIZE counters.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | input     | in_valid / in_ready | operation, index, delta, target
//   out     | output    | out_valid/out_ready | prefix_sum, found_position
//
// After reset the node store is swept to zero, one entry a cycle, and in_ready
// stays low until the sweep ends. One item is in work at a time. It walks the
// tree one level a cycle, limited by the single read port of the node store.
// The output register lets a new item start while a result waits; a stalled
// output holds the next result in the engine until the register frees.
module fenwick_tree_engine #(
  parameter int LOG_SIZE = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [LOG_SIZE:0]   index,
  input  logic signed [31:0]  delta,
  input  logic signed [31:0]  target,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  prefix_sum,
  output logic [LOG_SIZE:0]   found_position
);
  import fte_pkg::*;

  fte_cmd_t cmd;
  fte_sts_t sts;

  // Sequencing: sweep, intake, walk, result hand-off
  fte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Node store, walk arithmetic and output register
  fte_datapath #(
    .LOG_SIZE (LOG_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .index          (index),
    .delta          (delta),
    .target         (target),
    .prefix_sum     (prefix_sum),
    .found_position (found_position)
  );

endmodule

[tb/tb_fenwick_tree_engine.sv]
// Self-checking testbench for fenwick_tree_engine: directed corners, then random add/prefix/select traffic.
module tb_fenwick_tree_engine;
  import fte_pkg::*;

  localparam int LOG_SIZE = 10;
  localparam int unsigned TREE_SIZE = 1 << LOG_SIZE;
  localparam int unsigned MAX_INDEX = (1 << (LOG_SIZE + 1)) - 1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_ITEMS = 1000;
  localparam int CALM_FROM = 700;

  typedef struct {
    logic signed [31:0] sum;
    logic [LOG_SIZE:0] pos;
  } tree_answer_t;

  // Mirror of the node store plus the queue of answers still owed by the block.
  class fenwick_scoreboard;
    logic signed [31:0] nodes [0:TREE_SIZE];
    tree_answer_t answers_due[$];
    int errors;

    function new();
      foreach (nodes[i]) nodes[i] = '0;
      errors = 0;
    endfunction

    function logic signed [31:0] prefix_of(int unsigned idx);
      logic signed [31:0] acc;
      int unsigned p;
      acc = '0;
      p = (idx > TREE_SIZE) ? TREE_SIZE : idx;
      while (p != 0) begin
        acc += nodes[p];
        p -= p & (~p + 1);
      end
      return acc;
    endfunction

    function void note_item(logic [OP_W-1:0] op, int unsigned idx,
                            logic signed [31:0] amount, logic signed [31:0] bound);
      int unsigned p, probe, stride;
      logic signed [31:0] left;
      tree_answer_t ans;
      case (op)
        OP_ADD: begin
          // index zero and anything past the top fall straight through
          p = idx;
          while (p != 0 && p <= TREE_SIZE) begin
            nodes[p] += amount;
            p += p & (~p + 1);
          end
        end
        OP_PREFIX: begin
          ans.sum = prefix_of(idx);
          ans.pos = '0;
          answers_due.push_back(ans);
        end
        OP_SELECT: begin
          // descend from the top bit, comparing the remaining bound as signed
          p = 0;
          stride = TREE_SIZE;
          left = bound;
          while (stride != 0 && p < TREE_SIZE) begin
            probe = p + stride;
            if (probe <= TREE_SIZE && left >= nodes[probe]) begin
              p = probe;
              left -= nodes[probe];
            end
            stride >>= 1;
          end
          ans.sum = '0;
          ans.pos = p[LOG_SIZE:0];
          answers_due.push_back(ans);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [31:0] sum, logic [LOG_SIZE:0] pos);
      tree_answer_t want;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got prefix_sum %0d found_position %0d",
                 $time, sum, pos);
        return;
      end
      want = answers_due.pop_front();
      if (sum !== want.sum) begin
        errors++;
        $display("%0t: prefix_sum expected %0d got %0d", $time, want.sum, sum);
      end
      if (pos !== want.pos) begin
        errors++;
        $display("%0t: found_position expected %0d got %0d", $time, want.pos, pos);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] operation;
  logic [LOG_SIZE:0] index;
  logic signed [31:0] delta;
  logic signed [31:0] target;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] prefix_sum;
  logic [LOG_SIZE:0] found_position;

  bit idle_en = 1'b0;
  fenwick_scoreboard sb = new();

  fenwick_tree_engine #(.LOG_SIZE(LOG_SIZE)) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .index          (index),
    .delta          (delta),
    .target         (target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prefix_sum     (prefix_sum),
    .found_position (found_position)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input int unsigned idx,
                           input logic signed [31:0] amount, input logic signed [31:0] bound);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    operation = op;
    index = idx[LOG_SIZE:0];
    delta = amount;
    target = bound;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, idx, amount, bound);
  endtask

  // Receiver: random stall bursts while idling is allowed, always ready otherwise.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(prefix_sum, found_position);
    end
  end

  initial begin
    int counted;
    int roll;
    logic [OP_W-1:0] op;
    int unsigned idx;
    logic signed [31:0] amount;
    logic signed [31:0] bound;

    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_ADD;
    index = '0;
    delta = '0;
    target = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Corners on the empty tree: zero index, saturation, select at the top and below zero.
    send_item(OP_PREFIX, 0, 32'sd0, 32'sd0);
    send_item(OP_PREFIX, TREE_SIZE, 32'sd0, 32'sd0);
    send_item(OP_SELECT, 0, 32'sd0, 32'sd0);
    send_item(OP_SELECT, 0, 32'sd0, -32'sd1);
    // Adds and an unused operation that must be dropped, then a saturated prefix.
    send_item(OP_ADD, 0, 32'sd5, 32'sd0);
    send_item(OP_ADD, TREE_SIZE + 1, 32'sd7, 32'sd0);
    send_item(OP_ADD, MAX_INDEX, -32'sd1, -32'sd1);
    send_item(OP_UNUSED, MAX_INDEX, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(OP_PREFIX, MAX_INDEX, 32'sd0, 32'sd0);
    // Real adds at the edges, with wrapping amounts.
    send_item(OP_ADD, 1, 32'sh7fff_ffff, 32'sd0);
    send_item(OP_ADD, TREE_SIZE, 32'sh8000_0000, 32'sd0);
    send_item(OP_ADD, TREE_SIZE / 2, -32'sd1, 32'sd0);
    send_item(OP_ADD, 3, 32'sd1, 32'sd0);
    send_item(OP_PREFIX, 1, 32'sd0, 32'sd0);
    send_item(OP_PREFIX, TREE_SIZE - 1, 32'sd0, 32'sd0);
    send_item(OP_PREFIX, TREE_SIZE, 32'sd0, 32'sd0);
    send_item(OP_PREFIX, TREE_SIZE + 1, 32'sd0, 32'sd0);
    send_item(OP_SELECT, 0, 32'sd0, 32'sh7fff_ffff);
    send_item(OP_SELECT, 0, 32'sd0, 32'sh8000_0000);
    send_item(OP_SELECT, 0, 32'sd0, 32'sd0);
    send_item(OP_SELECT, 0, 32'sd0, -32'sd1);
    // Undo the extremes so random selects see a mostly monotone tree.
    send_item(OP_ADD, 1, 32'sh8000_0001, 32'sd0);
    send_item(OP_ADD, TREE_SIZE, 32'sh8000_0000, 32'sd0);
    send_item(OP_ADD, TREE_SIZE / 2, 32'sd1, 32'sd0);

    counted = 0;
    while (counted < NUM_ITEMS) begin
      // every third hundred runs without gaps; the tail runs flat out
      idle_en = (counted < CALM_FROM) && ((counted / 100) % 3 != 2);
      roll = $urandom_range(0, 99);
      amount = $urandom;
      bound = $urandom;
      if (roll < 40) begin
        op = OP_ADD;
        if ($urandom_range(0, 19) == 0)
          idx = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(TREE_SIZE + 1, MAX_INDEX);
        else
          idx = $urandom_range(1, TREE_SIZE);
        roll = $urandom_range(0, 99);
        if (roll < 70) amount = $urandom_range(0, 20);
        else if (roll < 92) amount = -$signed($urandom_range(0, 8));
        if (idx >= 1 && idx <= TREE_SIZE) counted++;
      end else if (roll < 68) begin
        op = OP_PREFIX;
        if ($urandom_range(0, 19) == 0) idx = $urandom_range(TREE_SIZE + 1, MAX_INDEX);
        else idx = $urandom_range(0, TREE_SIZE);
        counted++;
      end else if (roll < 95) begin
        op = OP_SELECT;
        idx = $urandom_range(0, MAX_INDEX);
        // aim near a real prefix so the walk lands somewhere interesting
        if ($urandom_range(0, 6) != 0)
          bound = sb.prefix_of($urandom_range(0, TREE_SIZE)) + $signed($urandom_range(0, 4)) - 2;
        counted++;
      end else begin
        op = OP_UNUSED;
        idx = $urandom_range(0, MAX_INDEX);
      end
      send_item(op, idx, amount, bound);
    end

    idle_en = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
    // let a trailing add finish and catch any stray result
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
